// ===== rtl/erm_pkg.sv =====
// Shared types, codes and constants for the ERM motor drive ramp block.
// No dependencies; imported by every module of the block.
package erm_pkg;

    localparam int unsigned AMP_SHIFT   = 12;
    localparam int unsigned MAX_PAIRS   = 3;
    localparam int unsigned AMP_GAIN    = 100;
    localparam int unsigned AMP_OFFSET  = 155;
    localparam int unsigned LEVEL_CAP   = 255;
    localparam int unsigned INT_SHIFT   = 8;

    localparam int unsigned AMP_LIST_N  = 2 * MAX_PAIRS;
    localparam int unsigned IDX_W       = (AMP_LIST_N > 1) ? $clog2(AMP_LIST_N) : 1;
    localparam int unsigned K_W         = $clog2(AMP_LIST_N + 1);

    localparam logic [14:0] RANGE_RST   = 15'd20000;
    localparam logic [14:0] RISE_RST    = 15'd62;
    localparam logic [14:0] FALL_RST    = 15'd15;

    typedef enum logic [1:0] {
        KIND_TICK = 2'd0,
        KIND_SET  = 2'd1,
        KIND_AMP  = 2'd2,
        KIND_STOP = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        CFG_LEVEL_RANGE  = 2'd0,
        CFG_RISE_STEP    = 2'd1,
        CFG_FALL_STEP    = 2'd2,
        CFG_BRAKE_FITTED = 2'd3
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ALU_ADD = 2'd0,
        ALU_SUB = 2'd1,
        ALU_MUL = 2'd2
    } t_alu_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PK_CMP,
        ST_PK_ADD,
        ST_PK_CHK,
        ST_SL_CMP,
        ST_SL_ADD,
        ST_SL_CLAMP,
        ST_SL_FCMP,
        ST_SL_SUB,
        ST_TICK_DONE,
        ST_EMIT,
        ST_SET_MUL,
        ST_SET_PEAK,
        ST_AMP_SCAN,
        ST_AMP_MUL,
        ST_AMP_ADD
    } t_state;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  intensity;
        logic [1:0]  pair_count;
        logic [15:0] hi_amp_0;
        logic [15:0] lo_amp_0;
        logic [15:0] hi_amp_1;
        logic [15:0] lo_amp_1;
        logic [15:0] hi_amp_2;
        logic [15:0] lo_amp_2;
    } t_in_item;

    typedef struct packed {
        logic [15:0] pwm_level;
        logic        level_changed;
        logic        brake_on;
    } t_out_item;

    typedef struct packed {
        logic [14:0] level_range;
        logic [14:0] rise_step;
        logic [14:0] fall_step;
        logic        brake_fitted;
    } t_cfg;

    typedef struct packed {
        t_alu_op     op;
        logic [16:0] a;
        logic [16:0] b;
    } t_alu_req;

    typedef struct packed {
        logic [31:0] res;
        logic        borrow;
        logic        zero;
    } t_alu_rsp;

endpackage

// ===== rtl/erm_alu.sv =====
// Shared arithmetic unit: add, subtract with borrow/zero flags, 16x16 multiply.
// Depends on erm_pkg.
module erm_alu (
    input  erm_pkg::t_alu_req i_req,
    output erm_pkg::t_alu_rsp o_rsp
);
    import erm_pkg::*;

    logic [17:0] diff;
    logic [17:0] sum;
    logic [31:0] prod;

    always_comb begin
        diff = {1'b0, i_req.a} - {1'b0, i_req.b};
        sum  = {1'b0, i_req.a} + {1'b0, i_req.b};
        prod = i_req.a[15:0] * i_req.b[15:0];
        unique case (i_req.op)
            ALU_ADD: o_rsp.res = 32'(sum);
            ALU_SUB: o_rsp.res = 32'(diff[16:0]);
            ALU_MUL: o_rsp.res = prod;
            default: o_rsp.res = '0;
        endcase
        o_rsp.borrow = diff[17];
        o_rsp.zero   = (diff[16:0] == 17'd0);
    end

endmodule

// ===== rtl/erm_ctrl.sv =====
// Sequencer for the ERM ramp: holds the drive state and steps the shared ALU
// through ticks, set and amplitude items. Depends on erm_pkg.
module erm_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  erm_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output erm_pkg::t_out_item o_out_data,
    input  erm_pkg::t_cfg      i_cfg,
    output erm_pkg::t_alu_req  o_alu_req,
    input  erm_pkg::t_alu_rsp  i_alu_rsp
);
    import erm_pkg::*;

    t_state      r_state, n_state;
    t_in_item    r_item;
    t_out_item   r_res, r_out;
    logic        r_out_valid;
    logic        r_halted, r_peak_active;
    logic [15:0] r_drive, r_prev;
    logic [14:0] r_goal, r_peak, r_t;
    logic [16:0] r_lvl, r_diff;
    logic [15:0] r_best;
    logic [K_W-1:0] r_k, r_kend;
    logic [7:0]  r_int;
    logic [8:0]  r_scaled;

    logic        in_acc;
    logic        out_load;
    logic [15:0] amp_all [6];
    logic [15:0] amp_list [AMP_LIST_N];
    logic [15:0] amp_cur;
    logic [1:0]  pairs;
    logic [K_W-1:0] k_next;
    logic [31:0] shifted;
    logic [8:0]  int_inc;

    assign in_acc   = i_in_valid && (r_state == ST_IDLE);
    assign out_load = (r_state == ST_EMIT) && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        amp_all[0] = r_item.hi_amp_0;
        amp_all[1] = r_item.lo_amp_0;
        amp_all[2] = r_item.hi_amp_1;
        amp_all[3] = r_item.lo_amp_1;
        amp_all[4] = r_item.hi_amp_2;
        amp_all[5] = r_item.lo_amp_2;
        for (int i = 0; i < AMP_LIST_N; i++) begin
            amp_list[i] = amp_all[i];
        end
        amp_cur = amp_list[r_k[IDX_W-1:0]];
    end

    assign pairs   = (32'(i_in_data.pair_count) > MAX_PAIRS) ? 2'(MAX_PAIRS)
                                                            : i_in_data.pair_count;
    assign k_next  = r_k + K_W'(1);
    assign shifted = i_alu_rsp.res >> AMP_SHIFT;
    assign int_inc = 9'(r_int) + 9'd1;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_in_data.kind == KIND_STOP) begin
                        n_state = ST_EMIT;
                    end else if (!r_halted) begin
                        unique case (i_in_data.kind)
                            KIND_TICK: n_state = r_peak_active ? ST_PK_CMP : ST_SL_CMP;
                            KIND_SET:  n_state = ST_SET_MUL;
                            KIND_AMP:  n_state = (pairs == 2'd0) ? ST_AMP_MUL : ST_AMP_SCAN;
                            default:   n_state = ST_IDLE;
                        endcase
                    end
                end
            end
            ST_PK_CMP:    n_state = i_alu_rsp.borrow ? ST_PK_ADD : ST_SL_CMP;
            ST_PK_ADD:    n_state = ST_PK_CHK;
            ST_PK_CHK:    n_state = i_alu_rsp.borrow ? ST_TICK_DONE : ST_SL_CMP;
            ST_SL_CMP: begin
                if (i_alu_rsp.borrow)    n_state = ST_SL_ADD;
                else if (i_alu_rsp.zero) n_state = ST_TICK_DONE;
                else                     n_state = ST_SL_FCMP;
            end
            ST_SL_ADD:    n_state = ST_SL_CLAMP;
            ST_SL_CLAMP:  n_state = ST_TICK_DONE;
            ST_SL_FCMP:   n_state = i_alu_rsp.borrow ? ST_TICK_DONE : ST_SL_SUB;
            ST_SL_SUB:    n_state = ST_TICK_DONE;
            ST_TICK_DONE: n_state = ST_EMIT;
            ST_EMIT:      n_state = out_load ? ST_IDLE : ST_EMIT;
            ST_SET_MUL:   n_state = (r_int == 8'd0) ? ST_IDLE : ST_SET_PEAK;
            ST_SET_PEAK:  n_state = ST_IDLE;
            ST_AMP_SCAN:  n_state = (k_next == r_kend) ? ST_AMP_MUL : ST_AMP_SCAN;
            ST_AMP_MUL:   n_state = (r_best == 16'd0) ? ST_IDLE : ST_AMP_ADD;
            ST_AMP_ADD:   n_state = ST_SET_MUL;
            default:      n_state = ST_IDLE;
        endcase
    end

    // ALU operand selection
    always_comb begin
        o_alu_req.op = ALU_SUB;
        o_alu_req.a  = r_lvl;
        o_alu_req.b  = 17'(r_peak);
        unique case (r_state)
            ST_PK_ADD, ST_SL_ADD: begin
                o_alu_req.op = ALU_ADD;
                o_alu_req.b  = 17'(i_cfg.rise_step);
            end
            ST_SL_CMP, ST_SL_CLAMP: begin
                o_alu_req.b  = 17'(r_goal);
            end
            ST_SL_FCMP: begin
                o_alu_req.a  = r_diff;
                o_alu_req.b  = 17'(i_cfg.fall_step);
            end
            ST_SL_SUB: begin
                o_alu_req.b  = 17'(i_cfg.fall_step);
            end
            ST_SET_MUL: begin
                o_alu_req.op = ALU_MUL;
                o_alu_req.a  = 17'(int_inc);
                o_alu_req.b  = 17'(i_cfg.level_range);
            end
            ST_SET_PEAK: begin
                o_alu_req.a  = 17'(r_t);
            end
            ST_AMP_SCAN: begin
                o_alu_req.a  = 17'(r_best);
                o_alu_req.b  = 17'(amp_cur);
            end
            ST_AMP_MUL: begin
                o_alu_req.op = ALU_MUL;
                o_alu_req.a  = 17'(r_best);
                o_alu_req.b  = 17'(AMP_GAIN);
            end
            ST_AMP_ADD: begin
                o_alu_req.op = ALU_ADD;
                o_alu_req.a  = 17'(r_scaled);
                o_alu_req.b  = 17'(AMP_OFFSET);
            end
            default: begin
                o_alu_req.op = ALU_SUB;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= r_res;
        end
    end

    // drive state, reset to zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_halted      <= 1'b0;
            r_peak_active <= 1'b0;
            r_drive       <= '0;
            r_prev        <= '0;
            r_goal        <= '0;
            r_peak        <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc && i_in_data.kind == KIND_STOP) begin
                        r_halted <= 1'b1;
                    end
                end
                ST_PK_CMP, ST_PK_CHK: begin
                    if (!i_alu_rsp.borrow) begin
                        r_peak        <= '0;
                        r_peak_active <= 1'b0;
                    end
                end
                ST_TICK_DONE: begin
                    r_drive <= r_lvl[15:0];
                    r_prev  <= r_lvl[15:0];
                end
                ST_SET_MUL: begin
                    if (r_int == 8'd0) begin
                        r_goal <= '0;
                    end
                end
                ST_SET_PEAK: begin
                    if (!i_alu_rsp.borrow && !i_alu_rsp.zero) begin
                        r_peak        <= r_t;
                        r_peak_active <= 1'b1;
                    end
                    r_goal <= r_t;
                end
                ST_AMP_MUL: begin
                    if (r_best == 16'd0) begin
                        r_goal <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    r_item <= i_in_data;
                    r_lvl  <= {1'b0, r_drive};
                    r_int  <= i_in_data.intensity;
                    r_best <= '0;
                    r_k    <= '0;
                    r_kend <= K_W'({pairs, 1'b0});
                    if (i_in_data.kind == KIND_STOP) begin
                        r_res <= '{pwm_level: 16'd0, level_changed: 1'b0,
                                   brake_on: i_cfg.brake_fitted};
                    end
                end
            end
            ST_PK_ADD, ST_SL_ADD, ST_SL_SUB: begin
                r_lvl <= i_alu_rsp.res[16:0];
            end
            ST_SL_CMP: begin
                r_diff <= i_alu_rsp.res[16:0];
            end
            ST_SL_CLAMP: begin
                if (!i_alu_rsp.borrow && !i_alu_rsp.zero) begin
                    r_lvl <= 17'(r_goal);
                end
            end
            ST_SL_FCMP: begin
                if (i_alu_rsp.borrow) begin
                    r_lvl <= 17'(r_goal);
                end
            end
            ST_TICK_DONE: begin
                r_res <= '{pwm_level: r_lvl[15:0],
                           level_changed: (r_lvl[15:0] != r_prev), brake_on: 1'b0};
            end
            ST_SET_MUL: begin
                r_t <= i_alu_rsp.res[INT_SHIFT +: 15];
            end
            ST_AMP_SCAN: begin
                if (i_alu_rsp.borrow) begin
                    r_best <= amp_cur;
                end
                r_k <= k_next;
            end
            ST_AMP_MUL: begin
                r_scaled <= (shifted > 32'(LEVEL_CAP)) ? 9'(LEVEL_CAP + 1) : shifted[8:0];
            end
            ST_AMP_ADD: begin
                r_int <= (i_alu_rsp.res > 32'(LEVEL_CAP)) ? 8'(LEVEL_CAP)
                                                          : i_alu_rsp.res[7:0];
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== rtl/erm_motor_drive_ramp_core.sv =====
// ERM motor drive ramp: tick items slew the PWM level toward the goal after an
// overdrive rise; set/amplitude items update goal and peak; stop halts the block.
// Items are stepped through the shared ALU one operation at a time, and a new item is
//   taken only once the last is done; an emit waits while the one-entry output
//   register is held by a stall. Sync active-low reset restores the config defaults
//   and zeroes level, goal, peak, overdrive and halt state.
module erm_motor_drive_ramp_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  erm_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output erm_pkg::t_out_item o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [14:0]        i_cfg_data
);
    import erm_pkg::*;

    t_cfg     r_cfg;
    t_alu_req alu_req;
    t_alu_rsp alu_rsp;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.level_range  <= RANGE_RST;
            r_cfg.rise_step    <= RISE_RST;
            r_cfg.fall_step    <= FALL_RST;
            r_cfg.brake_fitted <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_LEVEL_RANGE:  r_cfg.level_range  <= i_cfg_data;
                CFG_RISE_STEP:    r_cfg.rise_step    <= i_cfg_data;
                CFG_FALL_STEP:    r_cfg.fall_step    <= i_cfg_data;
                CFG_BRAKE_FITTED: r_cfg.brake_fitted <= i_cfg_data[0];
            endcase
        end
    end

    erm_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    erm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg       (r_cfg),
        .o_alu_req   (alu_req),
        .i_alu_rsp   (alu_rsp)
    );

endmodule

// ===== rtl/erm_checker.sv =====
// Port-level checks for the ERM ramp core, bound to the top level.
// Depends on erm_pkg.
module erm_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input erm_pkg::t_in_item  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input erm_pkg::t_out_item o_out_data
);
    import erm_pkg::*;

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result dropped or changed while stalled");

    // a stop transaction always produces a result, so input is busy next cycle
    a_stop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_data.kind == KIND_STOP |=> o_in_stall)
        else $error("stop transaction did not occupy the block");

    // brake only appears on a stop result, which reports level zero, unchanged
    a_brake_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.brake_on |->
            o_out_data.pwm_level == 16'd0 && !o_out_data.level_changed)
        else $error("brake result with nonzero level");

    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("output valid or busy right after reset");

endmodule

bind erm_motor_drive_ramp_core erm_checker u_erm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

// ===== tb/testbench.sv =====
// Self-checking testbench for erm_motor_drive_ramp_core: random and directed drive commands,
// a cycle-free level predictor and a result scoreboard. Depends on rtl/erm_pkg.sv and the core.
module testbench;
    import erm_pkg::*;

    localparam int unsigned SETTLE_CYCLES = 32;
    localparam int unsigned QUIET_LIMIT   = 2000;
    localparam int unsigned PHASE_ITEMS   = 125;

    logic        i_clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    t_in_item    in_data = '0;
    logic        out_stall = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [1:0]  cfg_idx = '0;
    logic [14:0] cfg_data = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    t_out_item   o_out_data;
    logic        o_cfg_ready;

    // command stream and outstanding results
    t_in_item    drive_cmds[$];
    t_out_item   due_reports[$];
    logic        in_taken = 1'b0;
    int unsigned in_idle_pct = 0;
    int unsigned out_stall_pct = 0;
    int unsigned errors = 0;
    int unsigned quiet_cycles = 0;

    // shadow copy of the block's registers and ramp state
    logic [14:0] reg_range;
    logic [14:0] reg_rise;
    logic [14:0] reg_fall;
    logic        reg_brake;
    logic [15:0] drive_lvl;
    logic [14:0] goal_lvl;
    logic [14:0] peak_lvl;
    logic        overdrive_armed;
    logic [15:0] last_tick_lvl;
    logic        stopped;

    erm_motor_drive_ramp_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    task automatic report_mismatch(string what);
        $display("ERROR @%0t: %s", $time, what);
        errors++;
    endtask

    function automatic void take_intensity(logic [7:0] inten);
        int unsigned t;
        if (inten == 8'd0) begin
            goal_lvl = '0;
            return;
        end
        t = ((32'(inten) + 32'd1) * 32'(reg_range)) >> INT_SHIFT;
        if (t[14:0] > peak_lvl) begin
            peak_lvl = t[14:0];
            overdrive_armed = 1'b1;
        end
        goal_lvl = t[14:0];
    endfunction

    // strongest band over the valid pairs, mapped onto the intensity scale
    function automatic logic [7:0] packet_intensity(t_in_item it);
        logic [15:0] amps[6];
        int unsigned best;
        int unsigned pairs;
        int unsigned v;
        amps = '{it.hi_amp_0, it.lo_amp_0, it.hi_amp_1, it.lo_amp_1, it.hi_amp_2, it.lo_amp_2};
        best = 0;
        pairs = (32'(it.pair_count) > MAX_PAIRS) ? MAX_PAIRS : 32'(it.pair_count);
        for (int k = 0; k < 2 * pairs; k++) begin
            if (amps[k] > best) best = 32'(amps[k]);
        end
        if (best == 0) return 8'd0;
        v = ((best * AMP_GAIN) >> AMP_SHIFT) + AMP_OFFSET;
        if (v > LEVEL_CAP) v = LEVEL_CAP;
        return v[7:0];
    endfunction

    function automatic void advance_tick();
        int unsigned lvl;
        lvl = 32'(drive_lvl);
        if (overdrive_armed) begin
            if (lvl < peak_lvl) lvl += reg_rise;
            if (lvl >= peak_lvl) begin
                peak_lvl = '0;
                overdrive_armed = 1'b0;
            end
        end
        if (!overdrive_armed) begin
            if (lvl < goal_lvl) begin
                lvl += reg_rise;
                if (lvl > goal_lvl) lvl = 32'(goal_lvl);
            end
            if (lvl > goal_lvl) begin
                if (lvl - goal_lvl < reg_fall) lvl = 32'(goal_lvl);
                else lvl -= reg_fall;
            end
        end
        drive_lvl = lvl[15:0];
    endfunction

    function automatic void apply_drive_item(t_in_item it);
        if (it.kind == KIND_STOP) begin
            stopped = 1'b1;
            due_reports.push_back(t_out_item'{pwm_level: 16'd0, level_changed: 1'b0,
                                              brake_on: reg_brake});
            return;
        end
        if (stopped) return;
        case (it.kind)
            KIND_SET: take_intensity(it.intensity);
            KIND_AMP: take_intensity(packet_intensity(it));
            default: begin
                advance_tick();
                due_reports.push_back(t_out_item'{pwm_level: drive_lvl,
                                                  level_changed: drive_lvl != last_tick_lvl,
                                                  brake_on: 1'b0});
                last_tick_lvl = drive_lvl;
            end
        endcase
    endfunction

    function automatic void take_reg(logic [1:0] idx, logic [14:0] val);
        case (t_cfg_reg'(idx))
            CFG_LEVEL_RANGE: reg_range = val;
            CFG_RISE_STEP:   reg_rise = val;
            CFG_FALL_STEP:   reg_fall = val;
            default:         reg_brake = val[0];
        endcase
    endfunction

    task automatic check_report(t_out_item got);
        t_out_item want;
        if (due_reports.size() == 0) begin
            report_mismatch($sformatf("result with nothing pending: %p", got));
            return;
        end
        want = due_reports.pop_front();
        if (got.pwm_level !== want.pwm_level)
            report_mismatch($sformatf("pwm_level %0d, want %0d", got.pwm_level, want.pwm_level));
        if (got.level_changed !== want.level_changed)
            report_mismatch($sformatf("level_changed %b, want %b",
                                      got.level_changed, want.level_changed));
        if (got.brake_on !== want.brake_on)
            report_mismatch($sformatf("brake_on %b, want %b", got.brake_on, want.brake_on));
    endtask

    // monitor: scoreboard, register shadow and watchdog, all on the rising edge
    always @(posedge i_clk) begin
        if (!rst_n) begin
            reg_range = RANGE_RST;
            reg_rise = RISE_RST;
            reg_fall = FALL_RST;
            reg_brake = 1'b0;
            drive_lvl = '0;
            goal_lvl = '0;
            peak_lvl = '0;
            overdrive_armed = 1'b0;
            last_tick_lvl = '0;
            stopped = 1'b0;
            in_taken <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall) check_report(o_out_data);
            if (cfg_valid && o_cfg_ready) take_reg(cfg_idx, cfg_data);
            if (in_valid && !o_in_stall) apply_drive_item(in_data);
            in_taken <= in_valid && !o_in_stall;
            if ((o_out_valid && !out_stall) || (cfg_valid && o_cfg_ready)
                    || (in_valid && !o_in_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // driver: one assignment per signal per falling edge
    always @(negedge i_clk) begin
        if (rst_n) begin
            if (!in_valid || in_taken) begin
                if (drive_cmds.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
                    in_data <= drive_cmds.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
            out_stall <= ($urandom_range(99) < out_stall_pct);
        end
    end

    function automatic logic [15:0] pick_amp();
        case ($urandom_range(7))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2, 3:    return 16'($urandom_range(255));
            4, 5:    return 16'($urandom_range(4200));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_in_item random_op();
        t_in_item it;
        int unsigned r;
        r = $urandom_range(99);
        if (r < 55) it.kind = KIND_TICK;
        else if (r < 80) it.kind = KIND_SET;
        else it.kind = KIND_AMP;
        case ($urandom_range(7))
            0:       it.intensity = 8'd0;
            1:       it.intensity = 8'hFF;
            default: it.intensity = 8'($urandom);
        endcase
        it.pair_count = 2'($urandom_range(3));
        it.hi_amp_0 = pick_amp();
        it.lo_amp_0 = pick_amp();
        it.hi_amp_1 = pick_amp();
        it.lo_amp_1 = pick_amp();
        it.hi_amp_2 = pick_amp();
        it.lo_amp_2 = pick_amp();
        return it;
    endfunction

    function automatic void push_op(t_kind k, logic [7:0] inten, int n);
        t_in_item it;
        for (int i = 0; i < n; i++) begin
            it = random_op();
            it.kind = k;
            it.intensity = inten;
            drive_cmds.push_back(it);
        end
    endfunction

    function automatic void push_amp(logic [1:0] cnt, logic [15:0] h0, logic [15:0] l0,
                                     logic [15:0] h1, logic [15:0] l1,
                                     logic [15:0] h2, logic [15:0] l2);
        t_in_item it;
        it = '0;
        it.kind = KIND_AMP;
        it.pair_count = cnt;
        it.hi_amp_0 = h0;
        it.lo_amp_0 = l0;
        it.hi_amp_1 = h1;
        it.lo_amp_1 = l1;
        it.hi_amp_2 = h2;
        it.lo_amp_2 = l2;
        drive_cmds.push_back(it);
    endfunction

    task automatic wait_quiet();
        while (drive_cmds.size() != 0 || in_valid || due_reports.size() != 0)
            @(posedge i_clk);
        // set and amplitude commands leave no result but may still be in progress
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_reg idx, logic [14:0] val);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic program_regs(logic [14:0] range, logic [14:0] rise, logic [14:0] fall,
                                logic brake);
        wait_quiet();
        write_reg(CFG_LEVEL_RANGE, range);
        write_reg(CFG_RISE_STEP, rise);
        write_reg(CFG_FALL_STEP, fall);
        write_reg(CFG_BRAKE_FITTED, {14'd0, brake});
    endtask

    task automatic set_idling(int unsigned mode);
        case (mode)
            0:       begin in_idle_pct = 0;  out_stall_pct = 0;  end
            1:       begin in_idle_pct = 83; out_stall_pct = 0;  end
            2:       begin in_idle_pct = 0;  out_stall_pct = 83; end
            default: begin in_idle_pct = 29; out_stall_pct = 29; end
        endcase
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        rst_n <= 1'b1;

        // directed: overdrive, clamped fall, pair counts and amplitude extremes
        program_regs(15'd20000, 15'd5000, 15'd3000, 1'b0);
        set_idling(0);
        push_op(KIND_TICK, 8'd0, 1);
        push_op(KIND_SET, 8'hFF, 1);
        push_op(KIND_TICK, 8'd0, 5);
        push_op(KIND_SET, 8'd1, 1);
        push_op(KIND_TICK, 8'd0, 7);
        push_op(KIND_SET, 8'd0, 1);
        push_op(KIND_TICK, 8'd0, 1);
        push_amp(2'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        push_amp(2'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        push_op(KIND_TICK, 8'd0, 1);
        push_amp(2'd1, 16'd0, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0);
        push_op(KIND_TICK, 8'd0, 1);
        push_amp(2'd3, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'h0800);
        push_amp(2'd3, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        push_op(KIND_TICK, 8'd0, 2);

        for (int p = 0; p < 8; p++) begin
            case (p)
                0: program_regs(RANGE_RST, RISE_RST, FALL_RST, 1'b0);
                1: program_regs(15'h7FFF, 15'd1, 15'd1, 1'b1);
                2: program_regs(15'd0, 15'd0, 15'd0, 1'b0);
                3: program_regs(15'd20000, 15'd20000, 15'd20000, 1'b1);
                4: program_regs(15'h7FFF, 15'h7FFF, 15'h7FFF, 1'b0);
                default: program_regs(15'($urandom_range(20000)),
                                      15'($urandom_range(1, 4000)),
                                      15'($urandom_range(1, 4000)),
                                      1'($urandom_range(1)));
            endcase
            set_idling(p % 4);
            for (int i = 0; i < PHASE_ITEMS; i++) drive_cmds.push_back(random_op());
        end

        // halted: only stops answer, register writes still land
        wait_quiet();
        write_reg(CFG_BRAKE_FITTED, 15'd0);
        set_idling(3);
        push_op(KIND_STOP, 8'd0, 1);
        push_op(KIND_TICK, 8'd0, 2);
        push_op(KIND_SET, 8'd200, 1);
        push_amp(2'd3, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        push_op(KIND_TICK, 8'd0, 1);
        wait_quiet();
        write_reg(CFG_BRAKE_FITTED, 15'h7FFF);
        push_op(KIND_STOP, 8'hFF, 1);
        push_op(KIND_TICK, 8'd0, 1);
        push_op(KIND_STOP, 8'd0, 1);
        wait_quiet();

        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/erm_pkg.sv
rtl/erm_alu.sv
rtl/erm_ctrl.sv
rtl/erm_motor_drive_ramp_core.sv
rtl/erm_checker.sv
tb/testbench.sv
